>>> rtl/task_priority_table_unit_macros.svh
// Assertion macros shared by the task priority table RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef TASK_PRIORITY_TABLE_UNIT_MACROS_SVH
`define TASK_PRIORITY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tpt_pkg.sv
// Types and constants for the task priority table.
// No dependencies; used by tpt_best, task_priority_table_unit and the testbench.
package tpt_pkg;

    localparam int TID_W         = 8;
    localparam int OWNER_W       = 16;
    localparam int PRIO_W        = 31;
    localparam int MAX_TASKS_DEF = 256;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_EDIT   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_EXEC   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [TID_W-1:0]    task_id;
        logic [OWNER_W-1:0]  owner_id;
        logic [PRIO_W-1:0]   task_priority;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [OWNER_W-1:0]  exec_owner_id;
    } result_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

>>> rtl/tpt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tpt_best.sv
// Running best-entry tracker used while the table is scanned.
// Depends on tpt_pkg.
module tpt_best #(
    parameter int IDX_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpt_pkg::scan_ctl_t          ctl,
    input  logic                        live,
    input  logic [IDX_W-1:0]            idx,
    input  logic [tpt_pkg::PRIO_W-1:0]  prio,
    input  logic [tpt_pkg::OWNER_W-1:0] owner,
    output logic                        any,
    output logic [IDX_W-1:0]            best_idx,
    output logic [tpt_pkg::OWNER_W-1:0] best_owner
);
    import tpt_pkg::*;

    logic                any_reg;
    logic                any_next;
    logic [PRIO_W-1:0]   prio_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic                take;

    // Ascending scan with >= leaves the higher task id on equal priority.
    assign take = ctl.sample && live && (!any_reg || (prio >= prio_reg));

    always_comb
    begin
        any_next = any_reg;
        if (ctl.clear)
        begin
            any_next = 1'b0;
        end
        else if (take)
        begin
            any_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.clear)
        begin
            prio_reg  <= prio;
            idx_reg   <= idx;
            owner_reg <= owner;
        end
    end

    assign any        = any_reg;
    assign best_idx   = idx_reg;
    assign best_owner = owner_reg;

endmodule

>>> rtl/task_priority_table_unit.sv
// Task priority table: add, edit and remove are applied on acceptance; execute scans
// all DEPTH entries one entry per cycle from the priority RAM, DEPTH being MAX_TASKS
// capped at 256; item_stall holds off further beats from the execute's acceptance
// until its result is loaded into the result register.
// The result register frees the input while a result beat waits downstream.
// Reset clears the live marks and the control state; the RAMs are not cleared.
`include "task_priority_table_unit_macros.svh"

module task_priority_table_unit #(
    parameter int MAX_TASKS = tpt_pkg::MAX_TASKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tpt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tpt_pkg::result_t result
);
    import tpt_pkg::*;

    localparam int TABLE_SPAN = 2 ** TID_W;
    localparam int DEPTH      = (MAX_TASKS < TABLE_SPAN) ? MAX_TASKS : TABLE_SPAN;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam logic [TID_W:0]   DEPTH_V = (TID_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [IDX_W-1:0]   scan_cnt_next;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [DEPTH-1:0]   live_reg;
    logic [DEPTH-1:0]   live_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;

    logic               accept;
    logic               in_range;
    logic [IDX_W-1:0]   wr_idx;
    logic               owner_we;
    logic               prio_we;
    logic               load;
    logic [OWNER_W-1:0] rd_owner;
    logic [PRIO_W-1:0]  rd_prio;
    scan_ctl_t          scan_ctl;
    logic               best_any;
    logic [IDX_W-1:0]   best_idx;
    logic [OWNER_W-1:0] best_owner;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign in_range   = ({1'b0, item.task_id} < DEPTH_V);
    assign wr_idx     = item.task_id[IDX_W-1:0];
    assign owner_we   = accept && in_range && (item.kind == KIND_ADD);
    assign prio_we    = accept && in_range
                        && ((item.kind == KIND_ADD)
                            || ((item.kind == KIND_EDIT) && live_reg[wr_idx]));
    assign load       = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    tpt_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (DEPTH)
    ) u_owner_ram (
        .clk   (clk),
        .we    (owner_we),
        .waddr (wr_idx),
        .wdata (item.owner_id),
        .raddr (scan_cnt_reg),
        .rdata (rd_owner)
    );

    tpt_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (DEPTH)
    ) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (wr_idx),
        .wdata (item.task_priority),
        .raddr (scan_cnt_reg),
        .rdata (rd_prio)
    );

    assign scan_ctl.clear  = accept && (item.kind == KIND_EXEC);
    assign scan_ctl.sample = rd_pend_reg;

    tpt_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .live       (live_reg[rd_idx_reg]),
        .idx        (rd_idx_reg),
        .prio       (rd_prio),
        .owner      (rd_owner),
        .any        (best_any),
        .best_idx   (best_idx),
        .best_owner (best_owner)
    );

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_EXEC))
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        live_next = live_reg;
        if (accept && in_range && (item.kind == KIND_ADD))
        begin
            live_next[wr_idx] = 1'b1;
        end
        else if (accept && in_range && (item.kind == KIND_REMOVE))
        begin
            live_next[wr_idx] = 1'b0;
        end
        else if (load && best_any)
        begin
            live_next[best_idx] = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_cnt_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            live_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_cnt_reg     <= scan_cnt_next;
            rd_pend_reg      <= (state_reg == ST_SCAN);
            live_reg         <= live_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_cnt_reg;
        if (load)
        begin
            result_reg.found         <= best_any;
            result_reg.exec_owner_id <= best_any ? best_owner : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TPT_ASSERT_NXT(a_exec_clears_winner, load && best_any, !live_reg[$past(best_idx)], "Executed task is still live.")
    `TPT_ASSERT_IMP(a_last_read_pending, state_reg == ST_LAST, rd_pend_reg && (rd_idx_reg == LAST_IDX), "Final table read missing before compare.")
    `TPT_ASSERT_IMP(a_empty_owner_zero, result_valid_reg && !result_reg.found, result_reg.exec_owner_id == '0, "Owner not zero on empty result.")
    `TPT_ASSERT_NXT(a_done_waits_for_slot, (state_reg == ST_DONE) && result_valid_reg && result_stall, state_reg == ST_DONE, "Result overwritten while stalled.")

endmodule

>>> test/task_priority_table_unit_test.sv
// Self-checking testbench for task_priority_table_unit: directed and random task beats.
// A table predictor works out each execute result, which is checked against the result beats.
// Depends on tpt_pkg and the task_priority_table_unit RTL.
`timescale 1ns / 100ps

module task_priority_table_unit_test;
    import tpt_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          TABLE_DEPTH  = MAX_TASKS_DEF;
    localparam int          HOLD_CYCLES  = 1200;
    localparam int          END_PAUSE    = 300;
    localparam int unsigned LIMIT_CYCLES = 1500000;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item_beat    = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_beat;

    logic    idle_on      = 1'b1;
    logic    hold_off     = 1'b0;

    logic                table_live  [TABLE_DEPTH];
    logic [OWNER_W-1:0]  table_owner [TABLE_DEPTH];
    logic [PRIO_W-1:0]   table_prio  [TABLE_DEPTH];
    result_t             exec_owner_q[$];

    int unsigned cycle_count    = 0;
    int          mismatch_count = 0;
    int          beats_sent     = 0;
    int          execs_checked  = 0;
    int          execs_found    = 0;

    task_priority_table_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("task_priority_table_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            result_stall <= 1'b1;
        else if (idle_on)
            result_stall <= ($urandom_range(0, 99) < 10);
        else
            result_stall <= 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (exec_owner_q.size() == 0)
                report_mismatch("result beat with no execute outstanding");
            else
            begin
                want = exec_owner_q.pop_front();
                execs_checked++;
                if (result_beat.found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              result_beat.found, want.found));
                if (result_beat.exec_owner_id !== want.exec_owner_id)
                    report_mismatch($sformatf("owner %0h, expected %0h",
                                              result_beat.exec_owner_id, want.exec_owner_id));
            end
        end
    end

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (table_live[i])
                n++;
        return n;
    endfunction

    // Applies one accepted beat to the table copy; execute queues the owner it should return.
    task automatic update_task_table(input item_t beat);
        result_t            outcome;
        int                 best_idx;
        logic [PRIO_W-1:0]  best_prio;
        best_idx  = -1;
        best_prio = '0;
        case (beat.kind)
            KIND_ADD:
            begin
                table_live[beat.task_id]  = 1'b1;
                table_owner[beat.task_id] = beat.owner_id;
                table_prio[beat.task_id]  = beat.task_priority;
            end
            KIND_EDIT:
            begin
                if (table_live[beat.task_id])
                    table_prio[beat.task_id] = beat.task_priority;
            end
            KIND_REMOVE:
                table_live[beat.task_id] = 1'b0;
            default:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (table_live[i] && (best_idx < 0 || table_prio[i] >= best_prio))
                    begin
                        best_idx  = i;
                        best_prio = table_prio[i];
                    end
                if (best_idx >= 0)
                begin
                    table_live[best_idx]  = 1'b0;
                    outcome.found         = 1'b1;
                    outcome.exec_owner_id = table_owner[best_idx];
                    execs_found++;
                end
                else
                begin
                    outcome.found         = 1'b0;
                    outcome.exec_owner_id = '0;
                end
                exec_owner_q.push_back(outcome);
            end
        endcase
    endtask

    // Offers one beat, idling first at random, and holds it until it is accepted.
    task automatic issue_request(input item_t beat);
        while (idle_on && $urandom_range(0, 99) < 10)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_beat  <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        beats_sent++;
        update_task_table(beat);
    endtask

    task automatic drain_results;
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (exec_owner_q.size() != 0);
    endtask

    function automatic item_t make_item(input kind_t kind, input int unsigned tid,
                                        input int unsigned owner, input int unsigned prio);
        item_t beat;
        beat.kind          = kind;
        beat.task_id       = tid[TID_W-1:0];
        beat.owner_id      = owner[OWNER_W-1:0];
        beat.task_priority = prio[PRIO_W-1:0];
        return beat;
    endfunction

    // A span of zero gives full-range priorities; a small span forces many equal priorities.
    function automatic item_t random_item(input int unsigned prio_span);
        item_t       beat;
        int unsigned pick;
        pick               = $urandom_range(0, 99);
        beat.task_id       = TID_W'($urandom_range(0, TABLE_DEPTH - 1));
        beat.owner_id      = OWNER_W'($urandom);
        beat.task_priority = PRIO_W'((prio_span == 0) ? $urandom
                                                      : $urandom_range(0, prio_span));
        if (pick < 35)
            beat.kind = KIND_ADD;
        else if (pick < 55)
            beat.kind = KIND_EDIT;
        else if (pick < 70)
            beat.kind = KIND_REMOVE;
        else
            beat.kind = KIND_EXEC;
        if ((beat.kind == KIND_EDIT || beat.kind == KIND_REMOVE) && $urandom_range(0, 3) != 0)
            for (int tries = 0; tries < 16 && !table_live[beat.task_id]; tries++)
                beat.task_id = TID_W'($urandom_range(0, TABLE_DEPTH - 1));
        return beat;
    endfunction

    task automatic test_empty_execute;
        issue_request(make_item(KIND_EXEC, 0, 0, 0));
        issue_request(make_item(KIND_EXEC, 255, 16'hFFFF, 32'h7FFF_FFFF));
        drain_results();
    endtask

    task automatic test_field_extremes;
        issue_request(make_item(KIND_ADD, 0, 16'h0000, 0));
        issue_request(make_item(KIND_ADD, 255, 16'hFFFF, 32'h7FFF_FFFF));
        issue_request(make_item(KIND_ADD, 128, 16'h5AA5, 32'h7FFF_FFFF));
        repeat (3)
            issue_request(make_item(KIND_EXEC, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_edit_remove;
        issue_request(make_item(KIND_EDIT, 7, 16'h1111, 32'h7FFF_FFFF));
        issue_request(make_item(KIND_EXEC, 7, 0, 0));
        issue_request(make_item(KIND_ADD, 7, 16'h0707, 10));
        issue_request(make_item(KIND_ADD, 9, 16'h0909, 5));
        issue_request(make_item(KIND_ADD, 9, 16'h9090, 20));
        issue_request(make_item(KIND_EDIT, 7, 16'h2222, 30));
        issue_request(make_item(KIND_REMOVE, 12, 0, 0));
        issue_request(make_item(KIND_EXEC, 0, 0, 0));
        issue_request(make_item(KIND_REMOVE, 9, 0, 0));
        issue_request(make_item(KIND_EXEC, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_equal_priorities;
        issue_request(make_item(KIND_ADD, 3, 16'h0003, 500));
        issue_request(make_item(KIND_ADD, 200, 16'h00C8, 500));
        issue_request(make_item(KIND_ADD, 77, 16'h004D, 500));
        issue_request(make_item(KIND_ADD, 150, 16'h0096, 500));
        repeat (4)
            issue_request(make_item(KIND_EXEC, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_random_mix(input int count, input int unsigned prio_span);
        for (int n = 0; n < count; n++)
            issue_request(random_item(prio_span));
        drain_results();
    endtask

    task automatic test_no_idle_burst;
        idle_on <= 1'b0;
        test_random_mix(250, 0);
        idle_on <= 1'b1;
    endtask

    task automatic test_back_pressure;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
            for (int n = 0; n < 6; n++)
            begin
                issue_request(make_item(KIND_ADD, $urandom_range(0, TABLE_DEPTH - 1),
                                        $urandom, $urandom));
                issue_request(make_item(KIND_EXEC, 0, 0, 0));
            end
        join
        drain_results();
    endtask

    task automatic test_drain_table;
        while (live_count() > 0)
            issue_request(make_item(KIND_EXEC, $urandom_range(0, TABLE_DEPTH - 1), 0, 0));
        repeat (2)
            issue_request(make_item(KIND_EXEC, $urandom_range(0, TABLE_DEPTH - 1), 0, 0));
        drain_results();
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            table_live[i]  = 1'b0;
            table_owner[i] = '0;
            table_prio[i]  = '0;
        end
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_execute();
        test_field_extremes();
        test_edit_remove();
        test_equal_priorities();
        test_random_mix(600, 0);
        test_random_mix(300, 3);
        test_no_idle_burst();
        test_back_pressure();
        test_random_mix(300, 1000);
        test_drain_table();

        repeat (END_PAUSE)
            @(posedge clk);
        $display("Sent %0d task beats of all four kinds, with random idling and a long hold-off.",
                 beats_sent);
        $display("Checked %0d execute results, %0d of them finding a live task.",
                 execs_checked, execs_found);
        if (mismatch_count == 0)
            $display("task_priority_table_unit: match");
        else
            $display("task_priority_table_unit: mismatch");
        $finish;
    end

endmodule
